// ===== src/rraes_pkg.sv =====
// shared types, constants and round functions of the reduced-round aes-128 engine
// no dependencies
package rraes_pkg;

	localparam int RD_W = 4;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_KEY_HIGH   = 3'd0;
	localparam logic [IDX_W-1:0] REG_KEY_LOW    = 3'd1;
	localparam logic [IDX_W-1:0] REG_IV_HIGH    = 3'd2;
	localparam logic [IDX_W-1:0] REG_IV_LOW     = 3'd3;
	localparam logic [IDX_W-1:0] REG_CHAIN_MODE = 3'd4;

	typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_RUN, ST_HOLD} state_t;

	typedef struct packed {
		logic            load;
		logic            step;
		logic            last;
		logic            finish;
		logic            kstart;
		logic            kstep;
		logic [RD_W-1:0] rd;
	} cmd_t;

	typedef logic [7:0] st_t [16];

	localparam logic [0:255][7:0] SBOX = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
	};

	localparam logic [0:255][7:0] INV_SBOX = {
		128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
	};

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] b, input logic [3:0] f);
		logic [7:0] acc;
		logic [7:0] v;
		acc = 8'h00;
		v = b;
		for (int i = 0; i < 4; i++) begin
			if (f[i]) acc = acc ^ v;
			v = xt(v);
		end
		return acc;
	endfunction

	function automatic st_t blk_to_st(input logic [127:0] b);
		st_t s;
		for (int i = 0; i < 16; i++) s[i] = b[127-8*i -: 8];
		return s;
	endfunction

	function automatic logic [127:0] st_to_blk(input st_t s);
		logic [127:0] b;
		for (int i = 0; i < 16; i++) b[127-8*i -: 8] = s[i];
		return b;
	endfunction

	// state row r, column c takes byte r of key word c
	function automatic st_t add_key(input st_t s, input logic [127:0] k);
		st_t o;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				o[r*4+c] = s[r*4+c] ^ k[127-8*(c*4+r) -: 8];
		return o;
	endfunction

	function automatic st_t sub_bytes(input st_t s, input logic inv);
		st_t o;
		for (int i = 0; i < 16; i++) o[i] = inv ? INV_SBOX[s[i]] : SBOX[s[i]];
		return o;
	endfunction

	function automatic st_t shift_rows(input st_t s, input logic inv);
		st_t o;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				if (inv) o[r*4+((r+c)%4)] = s[r*4+c];
				else o[r*4+c] = s[r*4+((r+c)%4)];
			end
		return o;
	endfunction

	function automatic st_t mix_columns(input st_t s, input logic inv);
		st_t o;
		logic [3:0] m [4];
		logic [7:0] v;
		if (inv) begin
			m[0] = 4'he; m[1] = 4'hb; m[2] = 4'hd; m[3] = 4'h9;
		end else begin
			m[0] = 4'h2; m[1] = 4'h3; m[2] = 4'h1; m[3] = 4'h1;
		end
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 4; j++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++) v = v ^ gmul(s[c+k*4], m[(k+4-j)%4]);
				o[c+j*4] = v;
			end
		return o;
	endfunction

	function automatic logic [127:0] expand_round(input logic [127:0] prev,
			input logic [7:0] rcon);
		logic [7:0] p [16];
		logic [7:0] n [16];
		logic [7:0] t [4];
		logic [127:0] o;
		for (int i = 0; i < 16; i++) p[i] = prev[127-8*i -: 8];
		for (int j = 0; j < 4; j++) t[j] = SBOX[p[12+((j+1)%4)]];
		t[0] = t[0] ^ rcon;
		for (int j = 0; j < 4; j++) begin
			n[j] = p[j] ^ t[j];
			n[4+j] = p[4+j] ^ n[j];
			n[8+j] = p[8+j] ^ n[4+j];
			n[12+j] = p[12+j] ^ n[8+j];
		end
		for (int i = 0; i < 16; i++) o[127-8*i -: 8] = n[i];
		return o;
	endfunction

endpackage

// ===== src/reduced_round_aes128_cbc_engine.sv =====
// top level of the reduced-round aes-128 ecb/cbc engine
// depends on rraes_pkg, rraes_ctrl, rraes_dp
//
//  channel  | signals                              | content
//  s_*      | tvalid tready tdata[127:0] tuser[1:0] | block request in
//  m_*      | tvalid tready tdata[127:0]            | result block out
//  cfg_*    | we index[2:0] wdata[63:0]            | key, iv, chain mode
//
// a block is loaded with the first round key added, then steps through each round
// in the shared round unit
// a key write re-expands the schedule, one round key per cycle
// input is taken again once the round unit is free; a stalled result waits
// in the output register and holds the last round until it can be written
module reduced_round_aes128_cbc_engine #(
	parameter int ROUND_COUNT = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // data_low, data_high
	input  logic [1:0]   s_tuser,  // first_block, func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // result_low, result_high
);
	import rraes_pkg::*;

	cmd_t cmd;

	rraes_ctrl #(.ROUND_COUNT(ROUND_COUNT)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .m_tvalid(m_tvalid),
		.m_tready(m_tready), .cmd(cmd)
	);

	rraes_dp #(.ROUND_COUNT(ROUND_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tdata(m_tdata), .cmd(cmd)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while round unit busy");
	a_busy_after_key: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW) |=> !s_tready)
		else $error("input accepted during key expansion");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid || m_tready))
		else $error("result overwritten while stalled");
`endif

endmodule

// ===== src/rraes_ctrl.sv =====
// controller state machine: key expansion sequencing, round counting, result hold
// depends on rraes_pkg
module rraes_ctrl #(
	parameter int ROUND_COUNT = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rraes_pkg::IDX_W-1:0] cfg_index,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output rraes_pkg::cmd_t             cmd
);
	import rraes_pkg::*;

	state_t state_q, state_d;
	logic [RD_W-1:0] cnt_q;
	logic ov_q;
	logic kwr, free, last;

	assign kwr = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
	assign free = !ov_q || m_tready;
	assign last = (cnt_q == RD_W'(ROUND_COUNT));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (kwr) state_d = ST_EXPAND;
				else if (s_tvalid) state_d = ST_RUN;
			end
			ST_EXPAND: begin
				if (!kwr && last) state_d = ST_IDLE;
			end
			ST_RUN: begin
				if (kwr) state_d = ST_EXPAND;
				else if (last) state_d = free ? ST_IDLE : ST_HOLD;
			end
			ST_HOLD: begin
				if (kwr) state_d = ST_EXPAND;
				else if (free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ST_IDLE) && !kwr;
		cmd.load   = s_tvalid && s_tready;
		cmd.kstart = kwr;
		cmd.kstep  = (state_q == ST_EXPAND) && !kwr;
		cmd.step   = (state_q == ST_RUN) && !kwr;
		cmd.last   = last;
		cmd.rd     = cnt_q;
		cmd.finish = free && !kwr
			&& (((state_q == ST_RUN) && last) || (state_q == ST_HOLD));
	end

	assign m_tvalid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (kwr || cmd.load) cnt_q <= RD_W'(1);
			else if (cmd.kstep || cmd.step) cnt_q <= cnt_q + RD_W'(1);
			if (cmd.finish) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
		end
	end

endmodule

// ===== src/rraes_dp.sv =====
// datapath: config registers, round key store, round unit, chaining and result registers
// depends on rraes_pkg
module rraes_dp #(
	parameter int ROUND_COUNT = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rraes_pkg::IDX_W-1:0] cfg_index,
	input  logic [63:0]                 cfg_wdata,
	input  logic [1:0]                  s_tuser,
	input  logic [127:0]                s_tdata,
	output logic [127:0]                m_tdata,
	input  rraes_pkg::cmd_t             cmd
);
	import rraes_pkg::*;

	localparam int CW = $clog2(ROUND_COUNT + 1);
	localparam int NK = ROUND_COUNT + 1;

	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic chain_mode_q;
	logic [127:0] kstore_q [NK];
	logic [127:0] ekey_q;
	logic [7:0] rcon_q;
	logic [127:0] chain_q, in_q, out_q;
	logic dec_q, cbc_q;
	st_t st_q, st_nxt, src;
	logic [127:0] key0, blk, ch, rk, res, knext;
	logic [CW-1:0] kidx, rdi;
	logic in_dec, first_cbc;

	assign rdi = cmd.rd[CW-1:0];
	assign in_dec = s_tuser[0];
	assign first_cbc = chain_mode_q && s_tuser[1];
	assign blk = {s_tdata[63:0], s_tdata[127:64]};
	assign ch = first_cbc ? {iv_high_q, iv_low_q} : chain_q;
	assign key0 = (cfg_index == REG_KEY_HIGH) ? {cfg_wdata, key_low_q} : {key_high_q, cfg_wdata};
	assign knext = expand_round(ekey_q, rcon_q);

	always_comb begin
		if (cmd.load) kidx = in_dec ? CW'(ROUND_COUNT) : '0;
		else kidx = dec_q ? CW'(ROUND_COUNT) - rdi : rdi;
	end
	assign rk = kstore_q[kidx];

	always_comb begin
		if (dec_q) begin
			st_nxt = add_key(sub_bytes(shift_rows(st_q, 1'b1), 1'b1), rk);
			if (!cmd.last) st_nxt = mix_columns(st_nxt, 1'b1);
		end else begin
			st_nxt = shift_rows(sub_bytes(st_q, 1'b0), 1'b0);
			if (!cmd.last) st_nxt = mix_columns(st_nxt, 1'b0);
			st_nxt = add_key(st_nxt, rk);
		end
		src = cmd.step ? st_nxt : st_q;
		res = st_to_blk(src) ^ ((cbc_q && dec_q) ? chain_q : 128'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q   <= '0;
			key_low_q    <= '0;
			iv_high_q    <= '0;
			iv_low_q     <= '0;
			chain_mode_q <= 1'b0;
			chain_q      <= '0;
			rcon_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY_HIGH:   key_high_q <= cfg_wdata;
					REG_KEY_LOW:    key_low_q <= cfg_wdata;
					REG_IV_HIGH:    iv_high_q <= cfg_wdata;
					REG_IV_LOW:     iv_low_q <= cfg_wdata;
					REG_CHAIN_MODE: chain_mode_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.kstart) rcon_q <= 8'h01;
			else if (cmd.kstep) rcon_q <= xt(rcon_q);
			if (cmd.load && first_cbc) chain_q <= {iv_high_q, iv_low_q};
			else if (cmd.finish && cbc_q) chain_q <= dec_q ? in_q : res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.kstart) begin
			ekey_q <= key0;
			kstore_q[0] <= key0;
		end else if (cmd.kstep) begin
			ekey_q <= knext;
			kstore_q[rdi] <= knext;
		end
		if (cmd.load) begin
			dec_q <= in_dec;
			cbc_q <= chain_mode_q;
			in_q  <= blk;
			st_q  <= add_key(blk_to_st((!in_dec && chain_mode_q) ? blk ^ ch : blk), rk);
		end else if (cmd.step) begin
			st_q <= st_nxt;
		end
		if (cmd.finish) out_q <= res;
	end

	assign m_tdata = {out_q[63:0], out_q[127:64]};

endmodule

// ===== sim/rraes_checker.sv =====
// checker for the reduced-round aes-128 engine: tracks configuration writes,
// predicts each result block from the accepted requests and compares
// depends on rraes_pkg for the register index names
module rraes_checker #(
	parameter int ROUND_COUNT = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	output int           errors,
	output int           pending
);
	import rraes_pkg::*;

	typedef logic [7:0] blk_bytes_t [16];

	logic [7:0]   fwd_box [256];
	logic [7:0]   inv_box [256];
	logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
	logic         cbc_on;
	logic [127:0] round_keys [ROUND_COUNT+1];
	logic [127:0] chain_blk;
	logic [127:0] expected_blocks [$];

	function automatic logic [7:0] times2(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] b, input logic [7:0] f);
		logic [7:0] acc;
		acc = 8'h00;
		while (f != 0) begin
			if (f[0]) acc = acc ^ b;
			b = times2(b);
			f = f >> 1;
		end
		return acc;
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] v, input int s);
		return (v << s) | (v >> (8 - s));
	endfunction

	function automatic blk_bytes_t to_bytes(input logic [127:0] b);
		blk_bytes_t s;
		for (int i = 0; i < 16; i++) s[i] = b[127-8*i -: 8];
		return s;
	endfunction

	function automatic logic [127:0] from_bytes(input blk_bytes_t s);
		logic [127:0] b;
		for (int i = 0; i < 16; i++) b[127-8*i -: 8] = s[i];
		return b;
	endfunction

	function automatic blk_bytes_t mix_key(input blk_bytes_t s, input logic [127:0] k);
		blk_bytes_t kb;
		kb = to_bytes(k);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) s[r*4+c] = s[r*4+c] ^ kb[c*4+r];
		return s;
	endfunction

	function automatic blk_bytes_t substitute(input blk_bytes_t s, input bit inv);
		for (int i = 0; i < 16; i++) s[i] = inv ? inv_box[s[i]] : fwd_box[s[i]];
		return s;
	endfunction

	function automatic blk_bytes_t rotate_rows(input blk_bytes_t s, input bit inv);
		blk_bytes_t o;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				if (inv) o[r*4+((r+c)%4)] = s[r*4+c];
				else o[r*4+c] = s[r*4+((r+c)%4)];
			end
		return o;
	endfunction

	function automatic blk_bytes_t mix_cols(input blk_bytes_t s, input bit inv);
		blk_bytes_t o;
		logic [7:0] m [4];
		logic [7:0] v;
		if (inv) begin
			m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
		end else begin
			m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
		end
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 4; j++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++) v = v ^ gf_mul(s[c+k*4], m[(k+4-j)%4]);
				o[c+j*4] = v;
			end
		return o;
	endfunction

	function automatic logic [127:0] cipher_fwd(input logic [127:0] b);
		blk_bytes_t s;
		s = mix_key(to_bytes(b), round_keys[0]);
		for (int rd = 1; rd < ROUND_COUNT; rd++)
			s = mix_key(mix_cols(rotate_rows(substitute(s, 0), 0), 0), round_keys[rd]);
		s = mix_key(rotate_rows(substitute(s, 0), 0), round_keys[ROUND_COUNT]);
		return from_bytes(s);
	endfunction

	function automatic logic [127:0] cipher_inv(input logic [127:0] b);
		blk_bytes_t s;
		s = mix_key(to_bytes(b), round_keys[ROUND_COUNT]);
		s = substitute(rotate_rows(s, 1), 1);
		for (int rd = ROUND_COUNT - 1; rd > 0; rd--)
			s = substitute(rotate_rows(mix_cols(mix_key(s, round_keys[rd]), 1), 1), 1);
		s = mix_key(s, round_keys[0]);
		return from_bytes(s);
	endfunction

	task automatic build_schedule();
		blk_bytes_t p, n;
		logic [7:0] t [4];
		logic [7:0] rc;
		p = to_bytes({key_hi, key_lo});
		round_keys[0] = {key_hi, key_lo};
		rc = 8'h00;
		for (int rd = 1; rd <= ROUND_COUNT; rd++) begin
			rc = (rd == 1) ? 8'h01 : times2(rc);
			for (int j = 0; j < 4; j++) t[j] = fwd_box[p[12+((j+1)%4)]];
			t[0] = t[0] ^ rc;
			for (int j = 0; j < 4; j++) begin
				n[j] = p[j] ^ t[j];
				n[4+j] = p[4+j] ^ n[j];
				n[8+j] = p[8+j] ^ n[4+j];
				n[12+j] = p[12+j] ^ n[8+j];
			end
			round_keys[rd] = from_bytes(n);
			p = n;
		end
	endtask

	initial begin
		logic [7:0] p, q;
		p = 8'h01;
		q = 8'h01;
		do begin
			p = p ^ times2(p);
			q = q ^ (q << 1);
			q = q ^ (q << 2);
			q = q ^ (q << 4);
			if (q[7]) q = q ^ 8'h09;
			fwd_box[p] = q ^ rot8(q, 1) ^ rot8(q, 2) ^ rot8(q, 3) ^ rot8(q, 4) ^ 8'h63;
		end while (p != 8'h01);
		fwd_box[0] = 8'h63;
		for (int i = 0; i < 256; i++) inv_box[fwd_box[i]] = i[7:0];
	end

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] din, dout, res;
		if (!arst_n) begin
			key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
			cbc_on = 1'b0;
			chain_blk = '0;
			expected_blocks.delete();
			errors = 0;
			for (int i = 0; i <= ROUND_COUNT; i++) round_keys[i] = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_HIGH: begin
						key_hi = cfg_wdata;
						build_schedule();
					end
					REG_KEY_LOW: begin
						key_lo = cfg_wdata;
						build_schedule();
					end
					REG_IV_HIGH: iv_hi = cfg_wdata;
					REG_IV_LOW: iv_lo = cfg_wdata;
					REG_CHAIN_MODE: cbc_on = cfg_wdata[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				// data_high in the low half of tdata
				din = {s_tdata[63:0], s_tdata[127:64]};
				if (cbc_on && s_tuser[1]) chain_blk = {iv_hi, iv_lo};
				if (!s_tuser[0]) begin
					dout = cipher_fwd(cbc_on ? din ^ chain_blk : din);
					if (cbc_on) chain_blk = dout;
				end else begin
					dout = cipher_inv(din);
					if (cbc_on) begin
						dout = dout ^ chain_blk;
						chain_blk = din;
					end
				end
				expected_blocks.push_back(dout);
			end
			if (m_tvalid && m_tready) begin
				res = {m_tdata[63:0], m_tdata[127:64]};
				if (expected_blocks.size() == 0) begin
					$display("%0t: unexpected result block %h", $time, res);
					errors++;
				end else begin
					dout = expected_blocks.pop_front();
					if (res[127:64] !== dout[127:64]) begin
						$display("%0t: result_high expected %h actual %h", $time,
							dout[127:64], res[127:64]);
						errors++;
					end
					if (res[63:0] !== dout[63:0]) begin
						$display("%0t: result_low expected %h actual %h", $time,
							dout[63:0], res[63:0]);
						errors++;
					end
				end
			end
		end
		pending = expected_blocks.size();
	end

endmodule

// ===== sim/tb.sv =====
// testbench top for the reduced-round aes-128 engine: drives configuration
// phases and block requests, and gives the verdict
// depends on rraes_pkg, reduced_round_aes128_cbc_engine, rraes_checker
module tb;
	import rraes_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd5;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 103;
	localparam int STALL_LIMIT = 5000;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	int           errors;
	int           pending;
	int           tx_idle_pct;
	int           rx_idle_pct;
	int           quiet_cycles;
	int           msg_left;
	bit           cbc_now;

	reduced_round_aes128_cbc_engine dut (.*);

	rraes_checker chk (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [63:0] rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_block(input bit dec, input bit first, input logic [63:0] hi,
			input logic [63:0] lo);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {first, dec};
		s_tdata <= {lo, hi};
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	task automatic configure(input logic [63:0] kh, input logic [63:0] kl,
			input logic [63:0] ivh, input logic [63:0] ivl, input bit cbc);
		@(negedge clk);
		s_tvalid <= 1'b0;
		drain();
		write_reg(REG_KEY_HIGH, kh);
		write_reg(REG_KEY_LOW, kl);
		write_reg(REG_IV_HIGH, ivh);
		write_reg(REG_IV_LOW, ivl);
		write_reg(REG_CHAIN_MODE, {63'd0, cbc});
		cbc_now = cbc;
		msg_left = 0;
	endtask

	task automatic random_block();
		bit first;
		if (cbc_now && $urandom_range(19) != 0) begin
			first = (msg_left == 0);
			if (first) msg_left = $urandom_range(1, 8);
			msg_left--;
		end else begin
			first = $urandom_range(1);
		end
		send_block($urandom_range(1), first, rand_word(), rand_word());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		tx_idle_pct = 17;
		rx_idle_pct = 47;
		quiet_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, both operations, ecb and cbc chaining
		configure('0, '0, '0, '0, 1'b0);
		write_reg(REG_UNUSED, '1);
		send_block(0, 0, '0, '0);
		send_block(1, 0, '0, '0);
		send_block(0, 1, '1, '1);
		send_block(1, 1, '1, '1);
		send_block(0, 0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		configure('1, '1, '1, '1, 1'b1);
		send_block(0, 1, '0, '1);
		send_block(0, 0, '1, '0);
		send_block(0, 0, 64'h0123456789abcdef, 64'hfedcba9876543210);
		send_block(1, 1, '0, '1);
		send_block(1, 0, '1, '0);
		send_block(1, 0, 64'h0123456789abcdef, 64'hfedcba9876543210);
		send_block(0, 1, 64'h8000000000000000, 64'h1);
		send_block(1, 0, 64'h1, 64'h8000000000000000);
		send_block(0, 0, '1, '1);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 3) begin
				tx_idle_pct = 47;
				rx_idle_pct = 17;
			end else if (ph == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (ph == PHASES - 1)
				configure('1, '0, '0, '1, ph[0]);
			else
				configure(rand_word(), rand_word(), rand_word(), rand_word(), ph[0]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold off until the pipeline is empty, then carry on
				if (i == PHASE_ITEMS / 2 && ph % 3 == 1) begin
					@(negedge clk);
					s_tvalid <= 1'b0;
					while (pending != 0) @(posedge clk);
				end
				random_block();
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		drain();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
